// ----- hdl/fdct_pkg.sv -----
// shared types, constants and helpers for the postscaled 8x8 forward dct
package fdct_pkg;

  localparam int FRAC_BITS = 14;

  localparam logic signed [16:0] K_0_707 = 17'sd11585;
  localparam logic signed [16:0] K_0_382 = 17'sd6270;
  localparam logic signed [16:0] K_0_541 = 17'sd8867;
  localparam logic signed [16:0] K_1_306 = 17'sd21407;

  typedef logic signed [29:0] wide_t;
  typedef logic signed [47:0] prod_t;

  typedef struct packed {
    logic signed [11:0] sample;
    logic [15:0]        scale;
  } pix_t;

  typedef struct packed {
    logic signed [15:0] coefficient;
    logic               last;
  } coef_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_READ, ST_GO, ST_WAIT, ST_WRITE, ST_QREAD, ST_QMUL, ST_QOUT
  } fsm_t;

  typedef struct packed {
    logic       ld;
    logic       go;
    logic       qmul;
    logic [2:0] idx;
  } bf_ctl_t;

  function automatic logic signed [33:0] descale(input prod_t x);
    prod_t y;
    y = (x + prod_t'(48'sd8192)) >>> FRAC_BITS;
    return y[33:0];
  endfunction

endpackage

// ----- hdl/fdct_ram.sv -----
// generic single write, single registered read memory
module fdct_ram #(
  parameter int WIDTH = 24,
  parameter int ABITS = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [2**ABITS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/fdct_bfly.sv -----
// aan 8-point butterfly stepped over one shared multiplier, also used for postscaling
module fdct_bfly (
  input  logic                clk,
  input  logic                rst,
  input  fdct_pkg::bf_ctl_t   ctl,
  input  logic signed [23:0]  ld_val,
  input  logic [15:0]         scale,
  output logic                done,
  output fdct_pkg::wide_t     o_sel,
  output fdct_pkg::prod_t     prod
);

  logic signed [23:0] v [8];
  fdct_pkg::wide_t o [8];
  fdct_pkg::wide_t ea, eb, ec, ed, d07, a, b, c, p, q;
  fdct_pkg::prod_t r;
  logic [2:0] step;

  fdct_pkg::wide_t s07, s34, s16, s25, d34, d16, d25, dd07;
  fdct_pkg::wide_t dsc, dsc_r;
  fdct_pkg::wide_t mul_a;
  logic signed [16:0] mul_b;

  always_comb begin
    s07  = fdct_pkg::wide_t'(v[0]) + fdct_pkg::wide_t'(v[7]);
    dd07 = fdct_pkg::wide_t'(v[0]) - fdct_pkg::wide_t'(v[7]);
    s34  = fdct_pkg::wide_t'(v[3]) + fdct_pkg::wide_t'(v[4]);
    d34  = fdct_pkg::wide_t'(v[3]) - fdct_pkg::wide_t'(v[4]);
    s16  = fdct_pkg::wide_t'(v[1]) + fdct_pkg::wide_t'(v[6]);
    d16  = fdct_pkg::wide_t'(v[1]) - fdct_pkg::wide_t'(v[6]);
    s25  = fdct_pkg::wide_t'(v[2]) + fdct_pkg::wide_t'(v[5]);
    d25  = fdct_pkg::wide_t'(v[2]) - fdct_pkg::wide_t'(v[5]);
    dsc   = fdct_pkg::wide_t'(fdct_pkg::descale(prod));
    dsc_r = fdct_pkg::wide_t'(fdct_pkg::descale(prod + r));
  end

  always_comb begin
    case (step)
      3'd2: begin
        mul_a = ed - eb;
        mul_b = fdct_pkg::K_0_707;
      end
      3'd3: begin
        mul_a = b;
        mul_b = fdct_pkg::K_0_707;
      end
      3'd4: begin
        mul_a = a - c;
        mul_b = fdct_pkg::K_0_382;
      end
      3'd5: begin
        mul_a = a;
        mul_b = fdct_pkg::K_0_541;
      end
      3'd6: begin
        mul_a = c;
        mul_b = fdct_pkg::K_1_306;
      end
      default: begin
        mul_a = o[ctl.idx];
        mul_b = {1'b0, scale};
      end
    endcase
  end

  assign done  = (step == 3'd7);
  assign o_sel = o[ctl.idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'd0;
    end else if (ctl.go) begin
      step <= 3'd1;
    end else if (step == 3'd7) begin
      step <= 3'd0;
    end else if (step != 3'd0) begin
      step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= fdct_pkg::prod_t'(mul_a) * fdct_pkg::prod_t'(mul_b);
    if (ctl.ld) begin
      v[ctl.idx] <= ld_val;
    end
    case (step)
      3'd1: begin
        ea  <= s07 + s34;
        eb  <= s07 - s34;
        ec  <= s25 + s16;
        ed  <= s25 - s16;
        d07 <= dd07;
        a   <= d34 + d25;
        b   <= d25 + d16;
        c   <= d16 + dd07;
      end
      3'd2: begin
        o[0] <= ea + ec;
        o[4] <= ea - ec;
      end
      3'd3: begin
        o[6] <= eb + dsc;
        o[2] <= eb - dsc;
      end
      3'd4: begin
        p <= d07 + dsc;
        q <= d07 - dsc;
      end
      3'd5: begin
        r <= prod;
      end
      3'd6: begin
        o[5] <= q + dsc_r;
        o[3] <= q - dsc_r;
      end
      3'd7: begin
        o[1] <= p + dsc_r;
        o[7] <= p - dsc_r;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/fdct8x8_postscaled.sv -----
// top level: load, row and column passes, postscale and coefficient output
//
//  channel | valid      | stall      | payload
//  input   | pix_valid  | pix_stall  | pix  (sample, scale)
//  output  | coef_valid | coef_stall | coef (coefficient, last)
//
// loading accepts one item per cycle while pix_valid is high, 64 items per block
// after the 64th item, 8 row passes and 8 column passes run on the single
// butterfly multiplier; no item is accepted while the passes run; coef_stall
// holds the output register and adds its stall cycles to the column passes
// reset returns to loading at position zero; store contents are kept
module fdct8x8_postscaled (
  input  logic            clk,
  input  logic            rst,
  input  logic            pix_valid,
  output logic            pix_stall,
  input  fdct_pkg::pix_t  pix,
  output logic            coef_valid,
  input  logic            coef_stall,
  output fdct_pkg::coef_t coef
);

  fdct_pkg::fsm_t state, state_next;
  logic [5:0] load_count;
  logic [3:0] cnt, cnt_next;
  logic [2:0] k, k_next;
  logic [3:0] pass, pass_next;

  fdct_pkg::bf_ctl_t ctl;
  logic done;
  fdct_pkg::wide_t o_sel;
  fdct_pkg::prod_t prod;

  logic [11:0] sample_q;
  logic [15:0] scale_q;
  logic [23:0] work_q;
  logic [5:0]  rd_addr, wr_addr, scale_raddr;
  logic        work_we, accept, out_free, out_load;
  logic signed [23:0] ld_val;
  logic signed [33:0] y;
  logic signed [15:0] sat;

  assign accept   = pix_valid && !pix_stall;
  assign pix_stall = (state != fdct_pkg::ST_LOAD);
  assign out_free = !coef_valid || !coef_stall;

  assign rd_addr = pass[3] ? {cnt[2:0], pass[2:0]} : {pass[2:0], cnt[2:0]};
  assign wr_addr = {pass[2:0], k};
  assign scale_raddr = {pass[2:0], k};
  assign ld_val = pass[3] ? $signed(work_q) : {{12{sample_q[11]}}, sample_q};

  fdct_ram #(.WIDTH(12), .ABITS(6)) u_sample (
    .clk(clk), .we(accept), .waddr(load_count), .wdata(pix.sample),
    .raddr(rd_addr), .rdata(sample_q)
  );

  fdct_ram #(.WIDTH(16), .ABITS(6)) u_scale (
    .clk(clk), .we(accept), .waddr(load_count), .wdata(pix.scale),
    .raddr(scale_raddr), .rdata(scale_q)
  );

  fdct_ram #(.WIDTH(24), .ABITS(6)) u_work (
    .clk(clk), .we(work_we), .waddr(wr_addr), .wdata(o_sel[23:0]),
    .raddr(rd_addr), .rdata(work_q)
  );

  fdct_bfly u_bfly (
    .clk(clk), .rst(rst), .ctl(ctl), .ld_val(ld_val), .scale(scale_q),
    .done(done), .o_sel(o_sel), .prod(prod)
  );

  always_comb begin
    y = fdct_pkg::descale(prod);
    if (y > 34'sd32767) begin
      sat = 16'sh7fff;
    end else if (y < -34'sd32768) begin
      sat = -16'sh8000;
    end else begin
      sat = y[15:0];
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    k_next     = k;
    pass_next  = pass;
    ctl        = '0;
    work_we    = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      fdct_pkg::ST_LOAD: begin
        if (accept && load_count == 6'd63) begin
          state_next = fdct_pkg::ST_READ;
          cnt_next   = 4'd0;
          pass_next  = 4'd0;
        end
      end
      fdct_pkg::ST_READ: begin
        ctl.ld  = (cnt != 4'd0);
        ctl.idx = 3'(cnt - 4'd1);
        cnt_next = cnt + 4'd1;
        if (cnt == 4'd8) begin
          state_next = fdct_pkg::ST_GO;
        end
      end
      fdct_pkg::ST_GO: begin
        ctl.go     = 1'b1;
        state_next = fdct_pkg::ST_WAIT;
      end
      fdct_pkg::ST_WAIT: begin
        k_next = 3'd0;
        if (done) begin
          state_next = pass[3] ? fdct_pkg::ST_QREAD : fdct_pkg::ST_WRITE;
        end
      end
      fdct_pkg::ST_WRITE: begin
        ctl.idx = k;
        work_we = 1'b1;
        k_next  = k + 3'd1;
        if (k == 3'd7) begin
          pass_next  = pass + 4'd1;
          cnt_next   = 4'd0;
          state_next = fdct_pkg::ST_READ;
        end
      end
      fdct_pkg::ST_QREAD: begin
        state_next = fdct_pkg::ST_QMUL;
      end
      fdct_pkg::ST_QMUL: begin
        ctl.qmul   = 1'b1;
        ctl.idx    = k;
        state_next = fdct_pkg::ST_QOUT;
      end
      fdct_pkg::ST_QOUT: begin
        ctl.idx = k;
        if (out_free) begin
          out_load = 1'b1;
          k_next   = k + 3'd1;
          if (k == 3'd7) begin
            if (pass == 4'd15) begin
              state_next = fdct_pkg::ST_LOAD;
            end else begin
              pass_next  = pass + 4'd1;
              cnt_next   = 4'd0;
              state_next = fdct_pkg::ST_READ;
            end
          end else begin
            state_next = fdct_pkg::ST_QREAD;
          end
        end
      end
      default: begin
        state_next = fdct_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= fdct_pkg::ST_LOAD;
      load_count <= 6'd0;
      cnt        <= 4'd0;
      k          <= 3'd0;
      pass       <= 4'd0;
      coef_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      k     <= k_next;
      pass  <= pass_next;
      if (accept) begin
        load_count <= load_count + 6'd1;
      end
      if (out_load) begin
        coef_valid <= 1'b1;
      end else if (!coef_stall) begin
        coef_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      coef.coefficient <= sat;
      coef.last        <= (pass == 4'd15) && (k == 3'd7);
    end
  end

endmodule

// ----- tb/tb_top.sv -----
// self-checking testbench for the postscaled 8x8 forward dct
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int K707 = 11585;
  localparam int K382 = 6270;
  localparam int K541 = 8867;
  localparam int K1306 = 21407;

  logic clk;
  logic rst;
  logic pix_valid;
  logic pix_stall;
  fdct_pkg::pix_t pix;
  logic coef_valid;
  logic coef_stall;
  fdct_pkg::coef_t coef;

  fdct8x8_postscaled u_top (
    .clk(clk), .rst(rst),
    .pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
    .coef_valid(coef_valid), .coef_stall(coef_stall), .coef(coef)
  );

  fdct_pkg::pix_t pending_pix[$];
  fdct_pkg::coef_t expected_coef[$];
  longint blk_sample[64];
  longint blk_scale[64];
  int fill_pos;
  int mismatches;
  int gap_left;
  int hold_left;
  int long_hold_req;

  function automatic longint round_shift(longint x);
    return (x + 64'sd8192) >>> 14;
  endfunction

  task automatic aan_pass(input longint v[8], output longint o[8]);
    longint s07, d07, s34, d34, s16, d16, s25, d25, ea, eb, ec, ed;
    longint z, a, b, c, p, q, r, m2, m4;
    s07 = v[0] + v[7]; d07 = v[0] - v[7];
    s34 = v[3] + v[4]; d34 = v[3] - v[4];
    s16 = v[1] + v[6]; d16 = v[1] - v[6];
    s25 = v[2] + v[5]; d25 = v[2] - v[5];
    ea = s07 + s34; eb = s07 - s34;
    ec = s25 + s16; ed = s25 - s16;
    o[0] = ea + ec;
    o[4] = ea - ec;
    z = round_shift((ed - eb) * K707);
    o[6] = eb + z;
    o[2] = eb - z;
    a = d34 + d25;
    b = round_shift((d25 + d16) * K707);
    c = d16 + d07;
    p = d07 + b;
    q = d07 - b;
    r = (a - c) * K382;
    m2 = round_shift(a * K541 + r);
    m4 = round_shift(c * K1306 + r);
    o[5] = q + m2;
    o[3] = q - m2;
    o[1] = p + m4;
    o[7] = p - m4;
  endtask

  task automatic predict_block();
    longint rows[64];
    longint v[8];
    longint o[8];
    longint y;
    fdct_pkg::coef_t e;
    fdct_pkg::coef_t outs[64];
    for (int rr = 0; rr < 8; rr++) begin
      for (int k = 0; k < 8; k++) v[k] = blk_sample[rr * 8 + k];
      aan_pass(v, o);
      for (int k = 0; k < 8; k++) rows[rr * 8 + k] = o[k];
    end
    for (int c = 0; c < 8; c++) begin
      for (int k = 0; k < 8; k++) v[k] = rows[k * 8 + c];
      aan_pass(v, o);
      for (int k = 0; k < 8; k++) begin
        y = round_shift(o[k] * blk_scale[c * 8 + k]);
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        e.coefficient = 16'(y);
        e.last = (c * 8 + k == 63);
        outs[c * 8 + k] = e;
      end
    end
    for (int k = 0; k < 64; k++) expected_coef.push_back(outs[k]);
  endtask

  task automatic accept_item(input fdct_pkg::pix_t p);
    blk_sample[fill_pos] = longint'(p.sample);
    blk_scale[fill_pos] = longint'(p.scale);
    if (fill_pos == 63) begin
      fill_pos = 0;
      predict_block();
    end else begin
      fill_pos++;
    end
  endtask

  function automatic int rand_gap();
    int w;
    w = $urandom_range(0, 99);
    if (w < 40) return 0;
    if (w < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic queue_item(input int s, input int q);
    fdct_pkg::pix_t p;
    p.sample = 12'(s);
    p.scale = 16'(q);
    pending_pix.push_back(p);
  endtask

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("fdct8x8_postscaled regression: fail");
    $finish;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      pix_valid <= 0;
      pix <= '0;
      gap_left <= 0;
    end else begin
      if (pix_valid && !pix_stall) begin
        accept_item(pix);
      end
      if (pix_valid && pix_stall) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        pix_valid <= 0;
        gap_left <= gap_left - 1;
      end else if (pending_pix.size() > 0) begin
        pix_valid <= 1;
        pix <= pending_pix.pop_front();
        gap_left <= rand_gap();
      end else begin
        pix_valid <= 0;
      end
    end
  end

  // monitor and receiver stall
  always @(posedge clk) begin
    if (rst) begin
      coef_stall <= 0;
      hold_left <= 0;
    end else begin
      if (coef_valid && !coef_stall) begin
        if (expected_coef.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected coef %0d last %0d",
                                         coef.coefficient, coef.last);
        end else begin
          fdct_pkg::coef_t e;
          e = expected_coef.pop_front();
          if (e !== coef) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp coef %0d last %0d, got coef %0d last %0d",
                       e.coefficient, e.last, coef.coefficient, coef.last);
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req <= 0;
        hold_left <= 1500;
        coef_stall <= 1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        coef_stall <= 1;
      end else begin
        coef_stall <= ($urandom_range(0, 99) < 25);
        if ($urandom_range(0, 99) < 2) hold_left <= $urandom_range(5, 40);
      end
    end
  end

  initial begin
    int drain;
    rst = 1;
    pix_valid = 0;
    pix = '0;
    coef_stall = 0;
    fill_pos = 0;
    mismatches = 0;
    long_hold_req = 0;
    // extremes: max samples with max scale, then min samples, alternating
    for (int i = 0; i < 64; i++) queue_item((i % 2) ? -2048 : 2047, 65535);
    // flat full-scale block
    for (int i = 0; i < 64; i++) queue_item(-2048, 65535);
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    long_hold_req <= 1;
    // random samples with a mix of full-range and small scales
    for (int i = 0; i < 64; i++)
      queue_item($urandom_range(0, 4095),
                 $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, 4096));
    wait (pending_pix.size() == 0);
    @(posedge clk);
    while (pix_valid) @(posedge clk);
    wait (expected_coef.size() == 0);
    drain = 0;
    while (drain < 600 && !coef_valid) begin
      @(posedge clk);
      drain++;
    end
    repeat (5) @(posedge clk);
    if (mismatches == 0 && expected_coef.size() == 0)
      $display("fdct8x8_postscaled regression: pass");
    else
      $display("fdct8x8_postscaled regression: fail");
    $finish;
  end

endmodule
